>>> hdl/gssl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gssl_pkg;

    // store depths
    localparam int MAX_SUBTABLES    = 16;
    localparam int COVERAGE_DEPTH   = 256;
    localparam int SUBSTITUTE_DEPTH = 256;

    // address and counter widths derived from the depths
    localparam int DESC_AW = (MAX_SUBTABLES > 1) ? $clog2(MAX_SUBTABLES) : 1;
    localparam int COV_AW  = (COVERAGE_DEPTH > 1) ? $clog2(COVERAGE_DEPTH) : 1;
    localparam int SUB_AW  = (SUBSTITUTE_DEPTH > 1) ? $clog2(SUBSTITUTE_DEPTH) : 1;
    localparam int KW      = $clog2(MAX_SUBTABLES + 1);

    // item actions
    typedef enum logic [1:0] {
        ACT_WR_DESC = 2'd0,
        ACT_WR_COV  = 2'd1,
        ACT_WR_SUB  = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    // coverage formats
    localparam logic [1:0] COV_LIST  = 2'd1;
    localparam logic [1:0] COV_RANGE = 2'd2;

    // substitution formats
    localparam logic SUB_DELTA = 1'b0;

    // subtable descriptor, 53 bits
    typedef struct packed {
        logic [1:0] cov_kind;
        logic       sub_kind;
        logic [15:0] delta;
        logic [7:0] cov_base;
        logic [8:0] cov_count;
        logic [7:0] sub_base;
        logic [8:0] sub_count;
    } desc_t;

    // coverage entry, 48 bits
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] last;
        logic [15:0] first;
    } cov_t;

    // walk sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_DESC_WAIT,
        ST_COV,
        ST_COV_EVAL,
        ST_SUB_CHK,
        ST_SUB_EVAL,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> hdl/gssl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gssl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/glyph_single_substitution_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-substitution glyph lookup.
// Input channel s_*: one item per transfer. Actions write a subtable
// descriptor, a coverage entry or a substitute word (accepted with no
// result), or query a glyph (one result on m_*: m_result_glyph and m_found).
// cfg_wr_en/cfg_wr_data set the number of subtables searched; write it only
// while no query is in flight.
// A query walks the subtables in order through one compare/add unit. Each
// subtable starts with a descriptor read, then compares its coverage entries
// in turn (memory read, then compare) and skips entries past the store's
// end; a subtable left without a substitution passes on to the next, and a
// word substitution reads the word. The result is then loaded into the
// output register, after a match or after a miss at the end of the walk.
// s_ready is low for the whole walk and returns as the result is loaded,
// so a new query waits for the last one to finish; writes are taken back
// to back while s_ready is high.
// A finished result sits in the output register; new writes are taken while
// it waits, and a later query holds at its end until m_ready frees the
// register. Reset clears the control state and the subtable count; the
// stores hold whatever was last written and need no clearing.
module glyph_single_substitution_lookup_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_slot,
    input  wire logic [1:0]  s_coverage_kind,
    input  wire logic        s_substitute_kind,
    input  wire logic signed [15:0] s_delta,
    input  wire logic [7:0]  s_coverage_base,
    input  wire logic [8:0]  s_coverage_count,
    input  wire logic [7:0]  s_substitute_base,
    input  wire logic [8:0]  s_substitute_count,
    input  wire logic [15:0] s_glyph,
    input  wire logic [15:0] s_range_end,
    input  wire logic [15:0] s_range_first_index,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_result_glyph,
    output logic             m_found
);

    gssl_pkg::state_t  state_reg, state_next;
    gssl_pkg::action_t act;

    logic [4:0]                 cfg_count_reg;
    logic [gssl_pkg::KW-1:0]    k_reg, k_next;
    logic [8:0]                 i_reg, i_next;
    logic [15:0]                glyph_reg, glyph_next;
    gssl_pkg::desc_t            desc_reg, desc_next;
    logic [16:0]                idx_reg, idx_next;
    logic [15:0]                res_glyph_reg, res_glyph_next;
    logic                       res_found_reg, res_found_next;
    logic                       m_valid_reg, m_valid_next;
    logic [15:0]                m_result_glyph_reg, m_result_glyph_next;
    logic                       m_found_reg, m_found_next;

    // store ports
    logic                          desc_we, desc_re;
    logic [gssl_pkg::DESC_AW-1:0]  desc_waddr, desc_raddr;
    gssl_pkg::desc_t               desc_wdata, desc_rdata;
    logic                          cov_we, cov_re;
    logic [gssl_pkg::COV_AW-1:0]   cov_waddr, cov_raddr;
    gssl_pkg::cov_t                cov_wdata, cov_rdata;
    logic                          sub_we, sub_re;
    logic [gssl_pkg::SUB_AW-1:0]   sub_waddr, sub_raddr;
    logic [15:0]                   sub_rdata;

    // shared compare/add unit
    logic        accept;
    logic        walk_done;
    logic        kind_ok;
    logic        cov_end;
    logic [9:0]  cov_pos;
    logic        cov_pos_ok;
    logic        cov_hit;
    logic [16:0] hit_idx;
    logic        sub_ok;
    logic [17:0] sub_pos;
    logic [15:0] delta_glyph;
    logic        out_free;

    assign act    = gssl_pkg::action_t'(s_action);
    assign accept = s_valid && s_ready;

    // walk conditions
    always_comb begin
        walk_done = (32'(k_reg) >= 32'(cfg_count_reg)) ||
                    (32'(k_reg) >= gssl_pkg::MAX_SUBTABLES);
        kind_ok = (desc_reg.cov_kind == gssl_pkg::COV_LIST) ||
                  (desc_reg.cov_kind == gssl_pkg::COV_RANGE);
        cov_end    = i_reg >= desc_reg.cov_count;
        cov_pos    = 10'(desc_reg.cov_base) + 10'(i_reg);
        cov_pos_ok = 32'(cov_pos) < gssl_pkg::COVERAGE_DEPTH;
        cov_hit = ((desc_reg.cov_kind == gssl_pkg::COV_LIST) &&
                   (cov_rdata.start == glyph_reg)) ||
                  ((desc_reg.cov_kind == gssl_pkg::COV_RANGE) &&
                   (cov_rdata.start <= glyph_reg) && (glyph_reg <= cov_rdata.last));
        if (desc_reg.cov_kind == gssl_pkg::COV_LIST) begin
            hit_idx = 17'(i_reg);
        end else begin
            hit_idx = 17'(cov_rdata.first) + 17'(glyph_reg - cov_rdata.start);
        end
        sub_pos = 18'(desc_reg.sub_base) + 18'(idx_reg);
        sub_ok  = (idx_reg < 17'(desc_reg.sub_count)) &&
                  (32'(sub_pos) < gssl_pkg::SUBSTITUTE_DEPTH);
        delta_glyph = glyph_reg + desc_reg.delta;
        out_free    = !m_valid_reg || m_ready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gssl_pkg::ST_IDLE: begin
                if (accept && act == gssl_pkg::ACT_QUERY) begin
                    state_next = gssl_pkg::ST_DESC;
                end
            end
            gssl_pkg::ST_DESC: begin
                state_next = walk_done ? gssl_pkg::ST_FINISH : gssl_pkg::ST_DESC_WAIT;
            end
            gssl_pkg::ST_DESC_WAIT: begin
                state_next = gssl_pkg::ST_COV;
            end
            gssl_pkg::ST_COV: begin
                priority if (!kind_ok || cov_end) begin
                    state_next = gssl_pkg::ST_DESC;
                end else if (cov_pos_ok) begin
                    state_next = gssl_pkg::ST_COV_EVAL;
                end else begin
                    state_next = gssl_pkg::ST_COV;
                end
            end
            gssl_pkg::ST_COV_EVAL: begin
                priority if (!cov_hit) begin
                    state_next = gssl_pkg::ST_COV;
                end else if (desc_reg.sub_kind == gssl_pkg::SUB_DELTA) begin
                    state_next = gssl_pkg::ST_FINISH;
                end else begin
                    state_next = gssl_pkg::ST_SUB_CHK;
                end
            end
            gssl_pkg::ST_SUB_CHK: begin
                state_next = sub_ok ? gssl_pkg::ST_SUB_EVAL : gssl_pkg::ST_DESC;
            end
            gssl_pkg::ST_SUB_EVAL: begin
                state_next = gssl_pkg::ST_FINISH;
            end
            gssl_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = gssl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gssl_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and store port control
    always_comb begin
        s_ready = (state_reg == gssl_pkg::ST_IDLE);

        desc_we    = s_valid && (state_reg == gssl_pkg::ST_IDLE) &&
                     (act == gssl_pkg::ACT_WR_DESC) &&
                     (32'(s_slot) < gssl_pkg::MAX_SUBTABLES);
        desc_waddr = gssl_pkg::DESC_AW'(s_slot);
        desc_wdata.cov_kind  = s_coverage_kind;
        desc_wdata.sub_kind  = s_substitute_kind;
        desc_wdata.delta     = s_delta;
        desc_wdata.cov_base  = s_coverage_base;
        desc_wdata.cov_count = s_coverage_count;
        desc_wdata.sub_base  = s_substitute_base;
        desc_wdata.sub_count = s_substitute_count;
        desc_re    = (state_reg == gssl_pkg::ST_DESC) && !walk_done;
        desc_raddr = gssl_pkg::DESC_AW'(k_reg);

        cov_we    = s_valid && (state_reg == gssl_pkg::ST_IDLE) &&
                    (act == gssl_pkg::ACT_WR_COV) &&
                    (32'(s_slot) < gssl_pkg::COVERAGE_DEPTH);
        cov_waddr = gssl_pkg::COV_AW'(s_slot);
        cov_wdata.start = s_glyph;
        cov_wdata.last  = s_range_end;
        cov_wdata.first = s_range_first_index;
        cov_re    = (state_reg == gssl_pkg::ST_COV);
        cov_raddr = gssl_pkg::COV_AW'(cov_pos);

        sub_we    = s_valid && (state_reg == gssl_pkg::ST_IDLE) &&
                    (act == gssl_pkg::ACT_WR_SUB) &&
                    (32'(s_slot) < gssl_pkg::SUBSTITUTE_DEPTH);
        sub_waddr = gssl_pkg::SUB_AW'(s_slot);
        sub_re    = (state_reg == gssl_pkg::ST_SUB_CHK);
        sub_raddr = gssl_pkg::SUB_AW'(sub_pos);
    end

    // walk datapath and output register
    always_comb begin
        k_next         = k_reg;
        i_next         = i_reg;
        glyph_next     = glyph_reg;
        desc_next      = desc_reg;
        idx_next       = idx_reg;
        res_glyph_next = res_glyph_reg;
        res_found_next = res_found_reg;

        unique case (state_reg)
            gssl_pkg::ST_IDLE: begin
                if (accept && act == gssl_pkg::ACT_QUERY) begin
                    glyph_next     = s_glyph;
                    k_next         = '0;
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                end
            end
            gssl_pkg::ST_DESC_WAIT: begin
                desc_next = desc_rdata;
                i_next    = '0;
            end
            gssl_pkg::ST_COV: begin
                priority if (!kind_ok || cov_end) begin
                    k_next = k_reg + 1'b1;
                end else if (!cov_pos_ok) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    i_next = i_reg;
                end
            end
            gssl_pkg::ST_COV_EVAL: begin
                if (cov_hit) begin
                    idx_next = hit_idx;
                    if (desc_reg.sub_kind == gssl_pkg::SUB_DELTA) begin
                        res_glyph_next = delta_glyph;
                        res_found_next = 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            gssl_pkg::ST_SUB_CHK: begin
                if (!sub_ok) begin
                    k_next = k_reg + 1'b1;
                end
            end
            gssl_pkg::ST_SUB_EVAL: begin
                res_glyph_next = sub_rdata;
                res_found_next = 1'b1;
            end
            default: begin
            end
        endcase

        m_valid_next        = m_valid_reg && !m_ready;
        m_result_glyph_next = m_result_glyph_reg;
        m_found_next        = m_found_reg;
        if (state_reg == gssl_pkg::ST_FINISH && out_free) begin
            m_valid_next        = 1'b1;
            m_result_glyph_next = res_glyph_reg;
            m_found_next        = res_found_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gssl_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            cfg_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg              <= k_next;
        i_reg              <= i_next;
        glyph_reg          <= glyph_next;
        desc_reg           <= desc_next;
        idx_reg            <= idx_next;
        res_glyph_reg      <= res_glyph_next;
        res_found_reg      <= res_found_next;
        m_result_glyph_reg <= m_result_glyph_next;
        m_found_reg        <= m_found_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_glyph = m_result_glyph_reg;
    assign m_found        = m_found_reg;

    // subtable descriptor store
    gssl_ram #(
        .WIDTH ($bits(gssl_pkg::desc_t)),
        .DEPTH (gssl_pkg::MAX_SUBTABLES)
    ) u_desc_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (desc_waddr),
        .wdata (desc_wdata),
        .re    (desc_re),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    // coverage entry store
    gssl_ram #(
        .WIDTH ($bits(gssl_pkg::cov_t)),
        .DEPTH (gssl_pkg::COVERAGE_DEPTH)
    ) u_cov_ram (
        .aclk  (aclk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata),
        .re    (cov_re),
        .raddr (cov_raddr),
        .rdata (cov_rdata)
    );

    // substitute word store
    gssl_ram #(
        .WIDTH (16),
        .DEPTH (gssl_pkg::SUBSTITUTE_DEPTH)
    ) u_sub_ram (
        .aclk  (aclk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (s_glyph),
        .re    (sub_re),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

`ifndef SYNTHESIS
    // a miss always reports glyph zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_result_glyph_reg == 16'd0)
        else $error("miss result carries a nonzero glyph");

    // a new result only comes from the end of a walk
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == gssl_pkg::ST_FINISH))
        else $error("result appeared outside the finish step");

    // an accepted query starts the walk at the first descriptor
    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == gssl_pkg::ACT_QUERY |=>
        state_reg == gssl_pkg::ST_DESC && k_reg == '0)
        else $error("query transfer did not start a walk");

    // subtable counter stays at or below MAX_SUBTABLES, one past the last descriptor slot
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != gssl_pkg::ST_IDLE |-> 32'(k_reg) <= gssl_pkg::MAX_SUBTABLES)
        else $error("subtable counter ran past the store");
`endif

endmodule

`default_nettype wire
